### src/elx_pkg.sv
// ---------------------------------------------------------------------------
// elx_pkg: shared types and constants of the expression lexer
// Token kinds, error codes, character codes, the keyword table and the
// result record that travels from the scanner to the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

package elx_pkg;

   // widths and sizes
   localparam int OFFSET_BITS   = 16;
   localparam int LEN_BITS      = 16;
   localparam int KW_COUNT      = 10;
   localparam int KW_IDX_BITS   = 4;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 3;

   // token kinds
   localparam logic [4:0] TK_NEWLINE  = 5'd0;
   localparam logic [4:0] TK_RPAREN   = 5'd1;
   localparam logic [4:0] TK_LPAREN   = 5'd2;
   localparam logic [4:0] TK_EQUAL    = 5'd3;
   localparam logic [4:0] TK_PLUS     = 5'd4;
   localparam logic [4:0] TK_MINUS    = 5'd5;
   localparam logic [4:0] TK_STAR     = 5'd6;
   localparam logic [4:0] TK_GREATER  = 5'd7;
   localparam logic [4:0] TK_LESS     = 5'd8;
   localparam logic [4:0] TK_COMMA    = 5'd9;
   localparam logic [4:0] TK_SEMI     = 5'd10;
   localparam logic [4:0] TK_IDENT    = 5'd11;
   localparam logic [4:0] TK_INT      = 5'd12;
   localparam logic [4:0] TK_FLOAT    = 5'd13;
   localparam logic [4:0] TK_EOF      = 5'd14;
   localparam logic [4:0] TK_KW_FIRST = 5'd15;

   // error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_CHAR = 2'd1;
   localparam logic [1:0] ERR_EXP  = 2'd2;

   // control characters
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   localparam logic [KW_COUNT-1:0] ALL_CAND = {KW_COUNT{1'b1}};

   // one result item
   typedef struct packed {
      logic [4:0]             kind;
      logic [OFFSET_BITS-1:0] start;
      logic [LEN_BITS-1:0]    length;
      logic [1:0]             err;
      logic                   last;
   } rsp_item_type;

   // up to two results from one byte, first one in a
   typedef struct packed {
      logic         a_valid;
      logic         b_valid;
      rsp_item_type a;
      rsp_item_type b;
   } push_type;

   // keyword length
   function automatic logic [2:0] kw_len(input logic [KW_IDX_BITS-1:0] idx);
      logic [2:0] len;
      case (idx)
         4'd0:    len = 3'd3;  // sin
         4'd1:    len = 3'd3;  // cos
         4'd2:    len = 3'd4;  // sin1
         4'd3:    len = 3'd4;  // cos1
         4'd4:    len = 3'd3;  // abs
         4'd5:    len = 3'd5;  // round
         4'd6:    len = 3'd4;  // sqrt
         4'd7:    len = 3'd3;  // tan
         4'd8:    len = 3'd4;  // tanh
         4'd9:    len = 3'd3;  // pow
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // keyword character at a position, first character at position 0
   function automatic logic [7:0] kw_char(input logic [KW_IDX_BITS-1:0] idx,
                                          input logic [2:0] pos);
      logic [39:0] word;
      logic [39:0] shifted;
      case (idx)
         4'd0:    word = {"sin", 16'h0};
         4'd1:    word = {"cos", 16'h0};
         4'd2:    word = {"sin1", 8'h0};
         4'd3:    word = {"cos1", 8'h0};
         4'd4:    word = {"abs", 16'h0};
         4'd5:    word = "round";
         4'd6:    word = {"sqrt", 8'h0};
         4'd7:    word = {"tan", 16'h0};
         4'd8:    word = {"tanh", 8'h0};
         4'd9:    word = {"pow", 16'h0};
         default: word = '0;
      endcase
      shifted = word << {pos, 3'b000};
      return shifted[39:32];
   endfunction

   // drop keywords that do not match character c at position len
   function automatic logic [KW_COUNT-1:0] kw_narrow(input logic [KW_COUNT-1:0] cand,
                                                     input logic [LEN_BITS-1:0] len,
                                                     input logic [7:0] c);
      logic [KW_COUNT-1:0] keep;
      for (int i = 0; i < KW_COUNT; i++) begin
         keep[i] = cand[i]
                   && (len < LEN_BITS'(kw_len(KW_IDX_BITS'(i))))
                   && (kw_char(KW_IDX_BITS'(i), len[2:0]) == c);
      end
      return keep;
   endfunction

   // identifier kind: the lowest surviving keyword of full length
   function automatic logic [4:0] kw_kind(input logic [KW_COUNT-1:0] cand,
                                          input logic [LEN_BITS-1:0] len);
      logic [4:0] kind;
      kind = TK_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (cand[i] && (len == LEN_BITS'(kw_len(KW_IDX_BITS'(i))))) begin
            kind = TK_KW_FIRST + 5'(i);
         end
      end
      return kind;
   endfunction

   // saturating length increment
   function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] len);
      return (len == {LEN_BITS{1'b1}}) ? len : len + LEN_BITS'(1);
   endfunction

endpackage

`default_nettype wire

### src/expression_lexer_core.sv
// ---------------------------------------------------------------------------
// expression_lexer_core: streaming tokenizer for a small expression language
// Input byte register, scanner and result queue.
// ---------------------------------------------------------------------------
// One source byte per transfer on req_, byte 0 ends the input. The block
// sustains one byte per cycle while the result queue has room. A byte that
// closes a pending token and also yields a token of its own gives two results,
// and the queue drains one result per cycle while the result side is ready.
// With the result side always ready, the input stalls only once the queue
// holds three results, which needs more two-result bytes than bytes that give
// no result at all. Bytes are registered at the input, results in the queue.
// After end of input or an error every byte is taken and dropped until
// reset. Token text is not kept: each result carries kind, start offset,
// length and error code, and rsp_tlast marks the last result of a byte.
`default_nettype none

module expression_lexer_core
   import elx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [4:0] token_kind, [20:5] start_offset,
                                         // [36:21] token_length, [38:37] error_code
   output logic             rsp_tlast
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   char_ff;
   logic         step_en;
   logic         room;
   push_type     push;
   rsp_item_type out_item;

   // input register handshake
   assign step_en    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || step_en;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
      end
   end

   // scanner
   elx_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .char_code (char_ff),
      .push      (push)
   );

   // result queue
   elx_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // result packing
   assign rsp_tdata = {1'b0, out_item.err, out_item.length, out_item.start, out_item.kind};
   assign rsp_tlast = out_item.last;

   a_step_needs_input: assert property (@(posedge clock) disable iff (reset)
      push.a_valid |-> in_valid_ff && room)
      else $error("result produced without a held byte");

endmodule

`default_nettype wire

### src/elx_scan.sv
// ---------------------------------------------------------------------------
// elx_scan: lexer state and one-byte scan step
// Holds the lexer state, offsets, text length and keyword candidates, and
// turns one byte into at most two results.
// ---------------------------------------------------------------------------
`default_nettype none

module elx_scan
   import elx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic [7:0] char_code,
   output push_type        push
);

   typedef enum logic [3:0] {
      ST_BEGIN,
      ST_COMMENT,
      ST_IDENT,
      ST_MINUS,
      ST_INT,
      ST_FRAC,
      ST_EXPMARK,
      ST_EXPDIGITS,
      ST_HALT
   } lex_state_type;

   lex_state_type          state_ff, state_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [KW_COUNT-1:0]    cand_ff, cand_in;

   rsp_item_type res_a, res_b;
   logic         a_v, b_v;
   logic         again;
   logic         is_alpha, is_digit, is_word;

   // character classes
   assign is_alpha = (char_code inside {["A":"Z"], ["a":"z"]});
   assign is_digit = (char_code inside {["0":"9"]});
   assign is_word  = is_alpha || is_digit || (char_code == "_");

   // scan step
   always_comb begin
      state_in  = state_ff;
      offset_in = offset_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      cand_in   = cand_ff;
      res_a     = '0;
      res_b     = '0;
      a_v       = 1'b0;
      b_v       = 1'b0;
      again     = 1'b0;

      // close or extend the token in progress
      case (state_ff)
         ST_BEGIN: begin
            again = 1'b1;
         end
         ST_COMMENT: begin
            if (char_code == CH_NUL || char_code == CH_LF) begin
               state_in = ST_BEGIN;
               again    = 1'b1;
            end
         end
         ST_IDENT: begin
            if (is_word) begin
               cand_in = kw_narrow(cand_ff, len_ff, char_code);
               len_in  = sat_inc(len_ff);
            end else begin
               a_v          = 1'b1;
               res_a.kind   = kw_kind(cand_ff, len_ff);
               res_a.start  = start_ff;
               res_a.length = len_ff;
               state_in     = ST_BEGIN;
               again        = 1'b1;
            end
         end
         ST_MINUS: begin
            if (is_digit) begin
               len_in   = sat_inc(len_ff);
               state_in = ST_INT;
            end else begin
               a_v          = 1'b1;
               res_a.kind   = TK_MINUS;
               res_a.start  = start_ff;
               res_a.length = LEN_BITS'(1);
               state_in     = ST_BEGIN;
               again        = 1'b1;
            end
         end
         ST_INT: begin
            if (is_digit) begin
               len_in = sat_inc(len_ff);
            end else if (char_code == ".") begin
               len_in   = sat_inc(len_ff);
               state_in = ST_FRAC;
            end else begin
               a_v          = 1'b1;
               res_a.kind   = TK_INT;
               res_a.start  = start_ff;
               res_a.length = len_ff;
               state_in     = ST_BEGIN;
               again        = 1'b1;
            end
         end
         ST_FRAC: begin
            if (is_digit) begin
               len_in = sat_inc(len_ff);
            end else if (char_code == "e") begin
               len_in   = sat_inc(len_ff);
               state_in = ST_EXPMARK;
            end else begin
               a_v          = 1'b1;
               res_a.kind   = TK_FLOAT;
               res_a.start  = start_ff;
               res_a.length = len_ff;
               state_in     = ST_BEGIN;
               again        = 1'b1;
            end
         end
         ST_EXPMARK: begin
            if (is_digit || char_code == "-") begin
               len_in   = sat_inc(len_ff);
               state_in = ST_EXPDIGITS;
            end else begin
               a_v          = 1'b1;
               res_a.kind   = TK_NEWLINE;
               res_a.start  = offset_ff;
               res_a.length = '0;
               res_a.err    = ERR_EXP;
               state_in     = ST_HALT;
            end
         end
         ST_EXPDIGITS: begin
            if (is_digit) begin
               len_in = sat_inc(len_ff);
            end else begin
               a_v          = 1'b1;
               res_a.kind   = TK_FLOAT;
               res_a.start  = start_ff;
               res_a.length = len_ff;
               state_in     = ST_BEGIN;
               again        = 1'b1;
            end
         end
         default: begin
            // halted: byte ignored
         end
      endcase

      // treat the byte as the start of a new token
      if (again) begin
         res_b.start  = offset_ff;
         res_b.length = LEN_BITS'(1);
         res_b.err    = ERR_NONE;
         case (char_code)
            " ", CH_TAB, CH_CR: begin
               b_v = 1'b0;
            end
            "%": begin
               state_in = ST_COMMENT;
            end
            CH_LF: begin
               b_v = 1'b1; res_b.kind = TK_NEWLINE;
            end
            ")": begin
               b_v = 1'b1; res_b.kind = TK_RPAREN;
            end
            "(": begin
               b_v = 1'b1; res_b.kind = TK_LPAREN;
            end
            "=": begin
               b_v = 1'b1; res_b.kind = TK_EQUAL;
            end
            "+": begin
               b_v = 1'b1; res_b.kind = TK_PLUS;
            end
            "*": begin
               b_v = 1'b1; res_b.kind = TK_STAR;
            end
            ">": begin
               b_v = 1'b1; res_b.kind = TK_GREATER;
            end
            "<": begin
               b_v = 1'b1; res_b.kind = TK_LESS;
            end
            ",": begin
               b_v = 1'b1; res_b.kind = TK_COMMA;
            end
            ";": begin
               b_v = 1'b1; res_b.kind = TK_SEMI;
            end
            CH_NUL: begin
               b_v          = 1'b1;
               res_b.kind   = TK_EOF;
               res_b.length = '0;
               state_in     = ST_HALT;
            end
            "-": begin
               state_in = ST_MINUS;
               start_in = offset_ff;
               len_in   = LEN_BITS'(1);
            end
            default: begin
               if (is_alpha) begin
                  state_in = ST_IDENT;
                  start_in = offset_ff;
                  cand_in  = kw_narrow(ALL_CAND, '0, char_code);
                  len_in   = LEN_BITS'(1);
               end else if (is_digit) begin
                  state_in = ST_INT;
                  start_in = offset_ff;
                  len_in   = LEN_BITS'(1);
               end else begin
                  b_v          = 1'b1;
                  res_b.kind   = TK_NEWLINE;
                  res_b.length = '0;
                  res_b.err    = ERR_CHAR;
                  state_in     = ST_HALT;
               end
            end
         endcase
      end

      // advance the byte offset, saturating
      if (char_code != CH_NUL && state_in != ST_HALT && offset_ff != {OFFSET_BITS{1'b1}}) begin
         offset_in = offset_ff + OFFSET_BITS'(1);
      end
   end

   // compact the results so that a single one is always in slot a
   always_comb begin
      push = '0;
      if (a_v) begin
         push.a_valid = step_en;
         push.b_valid = step_en && b_v;
         push.a       = res_a;
         push.a.last  = !b_v;
         push.b       = res_b;
         push.b.last  = 1'b1;
      end else begin
         push.a_valid = step_en && b_v;
         push.a       = res_b;
         push.a.last  = 1'b1;
         push.b       = res_b;
      end
   end

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_BEGIN;
         offset_ff <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         cand_ff   <= ALL_CAND;
      end else if (step_en) begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         cand_ff   <= cand_in;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HALT |=> state_ff == ST_HALT)
      else $error("lexer left the halted state");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HALT |-> !push.a_valid && $stable(offset_ff))
      else $error("halted lexer produced a result or moved its offset");

   a_err_len: assert property (@(posedge clock) disable iff (reset)
      push.a_valid && push.a.err != ERR_NONE |-> push.a.length == '0 && push.a.last)
      else $error("error result with nonzero length or not last");

endmodule

`default_nettype wire

### src/elx_rsp_fifo.sv
// ---------------------------------------------------------------------------
// elx_rsp_fifo: result queue
// Four-entry queue that takes up to two results per cycle and hands one per
// transfer to the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module elx_rsp_fifo
   import elx_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  push_type    push,
   output logic        room,
   output logic        out_valid,
   input  wire logic   out_ready,
   output rsp_item_type out_item
);

   rsp_item_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0] wr_next;
   logic [FIFO_CNT_BITS-1:0] push_n;
   logic                     pop;

   // status and read side
   assign room      = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // pointer and count update
   assign wr_next = wr_ptr_ff + FIFO_PTR_BITS'(1);
   assign push_n  = FIFO_CNT_BITS'(push.a_valid) + FIFO_CNT_BITS'(push.b_valid);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - FIFO_CNT_BITS'(pop);
   end

   // entry storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         if (push.a_valid && wr_ptr_ff == FIFO_PTR_BITS'(i)) begin
            entry_ff[i] <= push.a;
         end else if (push.b_valid && wr_next == FIFO_PTR_BITS'(i)) begin
            entry_ff[i] <= push.b;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.a_valid |-> room)
      else $error("result pushed without room in the queue");

   a_b_after_a: assert property (@(posedge clock) disable iff (reset)
      push.b_valid |-> push.a_valid)
      else $error("second result pushed without a first");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

### verif/tb_expression_lexer_core.sv
// ---------------------------------------------------------------------------
// tb_expression_lexer_core: self-checking bench for the expression lexer
// Streams one source text through req_, starting with a short opening table
// and continuing with random token sequences. The text ends with end of
// input or an error. A byte-level scanner model predicts every token, and
// results on rsp_ are checked in order while both sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_expression_lexer_core;
   import elx_pkg::*;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_BYTES  = 1400;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 16;

   // errors carry kind zero
   localparam logic [4:0] ERR_KIND = TK_NEWLINE;

   typedef enum logic [3:0] {
      SC_BEGIN, SC_COMMENT, SC_IDENT, SC_MINUS, SC_INT,
      SC_FRAC, SC_EXP_MARK, SC_EXP_DIGITS, SC_HALT
   } scan_phase_type;

   typedef struct packed {
      scan_phase_type         phase;
      logic [OFFSET_BITS-1:0] offset;
      logic [OFFSET_BITS-1:0] tok_start;
      logic [LEN_BITS-1:0]    tok_len;
      logic [KW_COUNT-1:0]    cand;
   } scan_state_type;

   typedef struct packed {
      logic [7:0]   ch;
      logic         pinned;
      rsp_item_type want;
   } text_row_type;

   localparam rsp_item_type NO_PIN = '0;

   // opening text: (sin1)=-9.5e-7+*><,-x;% <ff> <lf>
   localparam text_row_type OPENING [DIRECTED_ROWS] = '{
      '{"(", 1'b1, '{TK_LPAREN, 16'd0, 16'd1, ERR_NONE, 1'b1}},
      '{"s", 1'b0, NO_PIN}, '{"i", 1'b0, NO_PIN}, '{"n", 1'b0, NO_PIN},
      '{"1", 1'b0, NO_PIN}, '{")", 1'b0, NO_PIN},
      '{"=", 1'b1, '{TK_EQUAL, 16'd6, 16'd1, ERR_NONE, 1'b1}},
      '{"-", 1'b0, NO_PIN}, '{"9", 1'b0, NO_PIN}, '{".", 1'b0, NO_PIN},
      '{"5", 1'b0, NO_PIN}, '{"e", 1'b0, NO_PIN}, '{"-", 1'b0, NO_PIN},
      '{"7", 1'b0, NO_PIN}, '{"+", 1'b0, NO_PIN}, '{"*", 1'b0, NO_PIN},
      '{">", 1'b0, NO_PIN}, '{"<", 1'b0, NO_PIN}, '{",", 1'b0, NO_PIN},
      '{"-", 1'b0, NO_PIN}, '{"x", 1'b0, NO_PIN}, '{";", 1'b0, NO_PIN},
      '{"%", 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN}, '{CH_LF, 1'b0, NO_PIN}
   };

   string kw_word [KW_COUNT] = '{"sin", "cos", "sin1", "cos1", "abs",
                                 "round", "sqrt", "tan", "tanh", "pow"};

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;     // [7:0] char_code
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;           // [4:0] kind, [20:5] start, [36:21] length,
                                      // [38:37] error_code
   logic         rsp_tlast;

   text_row_type   source_text [$];
   rsp_item_type   pending_tokens [$];
   scan_state_type scan_plan;
   scan_state_type scan_live;
   int             taken_count    = 0;
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   int             hold_point     = 0;
   int             sink_hold      = 0;

   expression_lexer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // scanner model
   // ------------------------------------------------------------------
   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic [LEN_BITS-1:0] len_step(input logic [LEN_BITS-1:0] len);
      return (len == '1) ? len : len + 1'b1;
   endfunction

   function automatic rsp_item_type make_tok(input logic [4:0] kind,
                                             input logic [OFFSET_BITS-1:0] start,
                                             input logic [LEN_BITS-1:0] len,
                                             input logic [1:0] err);
      rsp_item_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = len;
      t.err    = err;
      t.last   = 1'b0;
      return t;
   endfunction

   // letter number pos of an identifier arrives: drop keywords that differ
   function automatic logic [KW_COUNT-1:0] trim_keywords(input logic [KW_COUNT-1:0] cand,
                                                         input int pos,
                                                         input logic [7:0] c);
      for (int i = 0; i < KW_COUNT; i++) begin
         if (cand[i] && (pos >= kw_word[i].len() || kw_word[i].getc(pos) != c))
            cand[i] = 1'b0;
      end
      return cand;
   endfunction

   function automatic logic [4:0] word_kind(input logic [KW_COUNT-1:0] cand,
                                            input logic [LEN_BITS-1:0] len);
      for (int i = 0; i < KW_COUNT; i++) begin
         if (cand[i] && len == kw_word[i].len())
            return TK_KW_FIRST + 5'(i);
      end
      return TK_IDENT;
   endfunction

   // one source byte: advance the scanner, return the number of tokens
   function automatic int scan_byte(inout scan_state_type s, input logic [7:0] c,
                                    output rsp_item_type [1:0] res);
      logic [OFFSET_BITS-1:0] pos;
      logic                   again;
      logic                   punct;
      logic [4:0]             pk;
      int                     n;
      pos   = s.offset;
      again = 1'b0;
      punct = 1'b0;
      pk    = TK_NEWLINE;
      n     = 0;
      res   = '0;
      if (s.phase == SC_HALT)
         return 0;

      // continue or close the pending token
      case (s.phase)
         SC_BEGIN: again = 1'b1;
         SC_COMMENT: begin
            if (c == CH_NUL || c == CH_LF) begin
               s.phase = SC_BEGIN;
               again   = 1'b1;
            end
         end
         SC_IDENT: begin
            if (is_word(c)) begin
               s.cand    = trim_keywords(s.cand, int'(s.tok_len), c);
               s.tok_len = len_step(s.tok_len);
            end else begin
               res[n] = make_tok(word_kind(s.cand, s.tok_len), s.tok_start, s.tok_len,
                                 ERR_NONE);
               n++;
               s.phase = SC_BEGIN;
               again   = 1'b1;
            end
         end
         SC_MINUS: begin
            if (is_digit(c)) begin
               s.tok_len = len_step(s.tok_len);
               s.phase   = SC_INT;
            end else begin
               res[n] = make_tok(TK_MINUS, s.tok_start, LEN_BITS'(1), ERR_NONE);
               n++;
               s.phase = SC_BEGIN;
               again   = 1'b1;
            end
         end
         SC_INT: begin
            if (is_digit(c)) begin
               s.tok_len = len_step(s.tok_len);
            end else if (c == ".") begin
               s.tok_len = len_step(s.tok_len);
               s.phase   = SC_FRAC;
            end else begin
               res[n] = make_tok(TK_INT, s.tok_start, s.tok_len, ERR_NONE);
               n++;
               s.phase = SC_BEGIN;
               again   = 1'b1;
            end
         end
         SC_FRAC: begin
            if (is_digit(c)) begin
               s.tok_len = len_step(s.tok_len);
            end else if (c == "e") begin
               s.tok_len = len_step(s.tok_len);
               s.phase   = SC_EXP_MARK;
            end else begin
               res[n] = make_tok(TK_FLOAT, s.tok_start, s.tok_len, ERR_NONE);
               n++;
               s.phase = SC_BEGIN;
               again   = 1'b1;
            end
         end
         SC_EXP_MARK: begin
            if (is_digit(c) || c == "-") begin
               s.tok_len = len_step(s.tok_len);
               s.phase   = SC_EXP_DIGITS;
            end else begin
               res[n] = make_tok(ERR_KIND, pos, '0, ERR_EXP);
               n++;
               s.phase = SC_HALT;
            end
         end
         default: begin
            if (is_digit(c)) begin
               s.tok_len = len_step(s.tok_len);
            end else begin
               res[n] = make_tok(TK_FLOAT, s.tok_start, s.tok_len, ERR_NONE);
               n++;
               s.phase = SC_BEGIN;
               again   = 1'b1;
            end
         end
      endcase

      // byte seen from the idle phase
      if (again) begin
         case (c)
            " ", CH_TAB, CH_CR: ;
            "%": s.phase = SC_COMMENT;
            "-": begin
               s.phase     = SC_MINUS;
               s.tok_start = pos;
               s.tok_len   = LEN_BITS'(1);
            end
            CH_NUL: begin
               res[n] = make_tok(TK_EOF, pos, '0, ERR_NONE);
               n++;
               s.phase = SC_HALT;
            end
            CH_LF: begin punct = 1'b1; pk = TK_NEWLINE; end
            ")":   begin punct = 1'b1; pk = TK_RPAREN;  end
            "(":   begin punct = 1'b1; pk = TK_LPAREN;  end
            "=":   begin punct = 1'b1; pk = TK_EQUAL;   end
            "+":   begin punct = 1'b1; pk = TK_PLUS;    end
            "*":   begin punct = 1'b1; pk = TK_STAR;    end
            ">":   begin punct = 1'b1; pk = TK_GREATER; end
            "<":   begin punct = 1'b1; pk = TK_LESS;    end
            ",":   begin punct = 1'b1; pk = TK_COMMA;   end
            ";":   begin punct = 1'b1; pk = TK_SEMI;    end
            default: begin
               if (is_alpha(c)) begin
                  s.phase     = SC_IDENT;
                  s.tok_start = pos;
                  s.cand      = trim_keywords(ALL_CAND, 0, c);
                  s.tok_len   = LEN_BITS'(1);
               end else if (is_digit(c)) begin
                  s.phase     = SC_INT;
                  s.tok_start = pos;
                  s.tok_len   = LEN_BITS'(1);
               end else begin
                  res[n] = make_tok(ERR_KIND, pos, '0, ERR_CHAR);
                  n++;
                  s.phase = SC_HALT;
               end
            end
         endcase
         if (punct) begin
            res[n] = make_tok(pk, pos, LEN_BITS'(1), ERR_NONE);
            n++;
         end
      end

      // offset of the next byte, saturating
      if (c != CH_NUL && s.phase != SC_HALT && s.offset != '1)
         s.offset = s.offset + 1'b1;
      if (n > 0)
         res[n-1].last = 1'b1;
      return n;
   endfunction

   function automatic void scan_reset(output scan_state_type s);
      s.phase     = SC_BEGIN;
      s.offset    = '0;
      s.tok_start = '0;
      s.tok_len   = '0;
      s.cand      = ALL_CAND;
   endfunction

   // ------------------------------------------------------------------
   // source text generation
   // ------------------------------------------------------------------
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_row(input text_row_type row);
      rsp_item_type [1:0] unused;
      void'(scan_byte(scan_plan, row.ch, unused));
      source_text.insert(source_text.size(), row);
   endfunction

   function automatic bit halts_on(input logic [7:0] c);
      scan_state_type     trial;
      rsp_item_type [1:0] unused;
      trial = scan_plan;
      void'(scan_byte(trial, c, unused));
      return trial.phase == SC_HALT;
   endfunction

   // body bytes never stop the scanner: a stopping byte becomes a digit
   function automatic void put_byte(input logic [7:0] c, input bit stop_ok);
      if (!stop_ok && halts_on(c))
         c = "1";
      add_row('{c, 1'b0, NO_PIN});
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   function automatic logic [7:0] rand_word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 52)
         return rand_letter();
      if (r < 62)
         return 8'("0" + r - 52);
      return "_";
   endfunction

   function automatic void put_digits(input int lo, input int hi);
      int cnt;
      cnt = $urandom_range(lo, hi);
      for (int k = 0; k < cnt; k++)
         put_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
   endfunction

   // one random token, mostly well formed, sometimes glued to the next one
   function automatic void add_token();
      string         punct_set;
      string         w;
      int            r;
      int            v;
      int            cnt;
      punct_set = "()=+*><,;";
      r = $urandom_range(0, 99);
      if (r < 12) begin
         cnt = $urandom_range(1, 3);
         for (int k = 0; k < cnt; k++) begin
            v = $urandom_range(0, 2);
            put_byte(v == 0 ? 8'(" ") : (v == 1 ? CH_TAB : CH_CR), 1'b0);
         end
      end else if (r < 24) begin
         v = $urandom_range(0, punct_set.len());
         put_byte(v == punct_set.len() ? CH_LF : punct_set.getc(v), 1'b0);
      end else if (r < 44) begin
         // keyword, keyword prefix or keyword with a tail
         w = kw_word[$urandom_range(0, KW_COUNT - 1)];
         v = $urandom_range(0, 99);
         cnt = (v >= 55 && v < 70) ? w.len() - 1 : w.len();
         for (int k = 0; k < cnt; k++)
            put_byte(w.getc(k), 1'b0);
         if (v >= 70)
            put_byte(rand_word_char(), 1'b0);
      end else if (r < 56) begin
         put_byte(rand_letter(), 1'b0);
         cnt = $urandom_range(0, 8);
         for (int k = 0; k < cnt; k++)
            put_byte(rand_word_char(), 1'b0);
      end else if (r < 68) begin
         if ($urandom_range(0, 9) < 3)
            put_byte("-", 1'b0);
         put_digits(1, 6);
      end else if (r < 80) begin
         // float with optional exponent
         if ($urandom_range(0, 9) < 3)
            put_byte("-", 1'b0);
         put_digits(1, 3);
         put_byte(".", 1'b0);
         put_digits(0, 3);
         if ($urandom_range(0, 1)) begin
            put_byte("e", 1'b0);
            v = $urandom_range(0, 2);
            if (v != 0)
               put_byte("-", 1'b0);
            if (v != 2)
               put_digits(1, 3);
         end
      end else if (r < 86) begin
         put_byte("%", 1'b0);
         cnt = $urandom_range(0, 15);
         for (int k = 0; k < cnt; k++)
            put_byte(8'($urandom_range(1, 255)), 1'b0);
         put_byte(CH_LF, 1'b0);
      end else if (r < 92) begin
         put_byte("-", 1'b0);
         v = $urandom_range(0, 2);
         put_byte(v == 0 ? 8'(" ") : (v == 1 ? rand_letter() : 8'("(")), 1'b0);
      end else begin
         put_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      if ($urandom_range(0, 1))
         put_byte(" ", 1'b0);
   endfunction

   function automatic void build_source_text();
      logic [7:0] c;
      int         mode;
      scan_reset(scan_plan);
      foreach (OPENING[i])
         add_row(OPENING[i]);
      while (source_text.size() < DIRECTED_ROWS + RANDOM_BYTES)
         add_token();

      // end of input, unknown character or broken exponent
      if (scan_plan.phase == SC_COMMENT)
         put_byte(CH_LF, 1'b0);
      mode = $urandom_range(0, 2);
      if (mode == 0) begin
         put_byte(CH_NUL, 1'b1);
      end else if (mode == 1) begin
         if ($urandom_range(0, 1))
            put_byte(" ", 1'b0);
         do c = 8'($urandom_range(1, 255)); while (!halts_on(c));
         put_byte(c, 1'b1);
      end else begin
         put_byte(" ", 1'b0);
         put_byte("1", 1'b0);
         put_byte(".", 1'b0);
         put_byte("5", 1'b0);
         put_byte("e", 1'b0);
         do c = 8'($urandom_range(0, 255)); while (is_digit(c) || c == "-");
         put_byte(c, 1'b1);
      end

      // bytes after the stop are dropped by the block
      for (int k = 0; k < 16; k++)
         source_text.insert(source_text.size(),
                            '{8'($urandom_range(0, 255)), 1'b0, NO_PIN});
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic log_token_error(input string why, input rsp_item_type want,
                                  input rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: want kind %0d start %0d len %0d err %0d last %0d", why,
                  want.kind, want.start, want.length, want.err, want.last,
                  " / got kind %0d start %0d len %0d err %0d last %0d",
                  got.kind, got.start, got.length, got.err, got.last);
   endtask

   // predict on each req transfer, compare on each rsp transfer
   always @(posedge clock) begin : token_check
      rsp_item_type [1:0] predicted;
      rsp_item_type       got;
      rsp_item_type       want;
      text_row_type       row;
      int                 n;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            row = source_text[taken_count];
            taken_count++;
            n = scan_byte(scan_live, req_tdata, predicted);
            if (row.pinned) begin
               pending_tokens.insert(pending_tokens.size(), row.want);
            end else begin
               for (int k = 0; k < n; k++)
                  pending_tokens.insert(pending_tokens.size(), predicted[k]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = rsp_tdata[4:0];
            got.start  = rsp_tdata[20:5];
            got.length = rsp_tdata[36:21];
            got.err    = rsp_tdata[38:37];
            got.last   = rsp_tlast;
            if (pending_tokens.size() == 0) begin
               log_token_error("unexpected token", NO_PIN, got);
            end else begin
               want = pending_tokens.pop_front();
               if (got.kind != want.kind || got.start != want.start ||
                   got.length != want.length || got.err != want.err ||
                   got.last != want.last)
                  log_token_error("token mismatch", want, got);
            end
         end
      end
   end

   // result side back-pressure, with calm stretches
   always @(posedge clock) begin : rsp_sink
      int span;
      span = (((cycle_count / 512) % 4) == 1) ? 0 : idle_span();
      if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold = sink_hold - 1;
      end else if (span > 0) begin
         rsp_tready <= 1'b0;
         sink_hold = span - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // source byte feed
   // ------------------------------------------------------------------
   initial begin
      int gap;
      build_source_text();
      scan_reset(scan_live);
      hold_point = DIRECTED_ROWS + $urandom_range(200, 1200);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < source_text.size(); i++) begin
         // let every pending token come out
         if (i == DIRECTED_ROWS || i == hold_point) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_tokens.size() != 0)
               @(posedge clock);
         end
         if (((i / 150) % 5) == 2)
            gap = 0;
         else
            gap = idle_span();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= source_text[i].ch;
         @(posedge clock);
         while (!req_tready)
            @(posedge clock);
      end
      req_tvalid <= 1'b0;

      // drain
      @(posedge clock);
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_tokens.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### sim.f
src/elx_pkg.sv
src/elx_scan.sv
src/elx_rsp_fifo.sv
src/expression_lexer_core.sv
verif/tb_expression_lexer_core.sv
